### sv/bdc_pkg.sv
// Shared types, constants and helpers for the block redistribution counter.
package bdc_pkg;

	localparam int MAX_RANKS = 64;
	localparam int DATA_W    = 32;
	localparam int RANK_W    = 6;
	localparam int GRP_W     = 7;
	localparam int STEP_W    = $clog2(DATA_W);

	typedef struct packed {
		logic              cmd;
		logic [DATA_W-1:0] total_elements;
		logic [RANK_W-1:0] my_rank;
		logic [GRP_W-1:0]  source_ranks;
		logic [GRP_W-1:0]  dest_ranks;
	} in_word_t;

	typedef struct packed {
		logic [RANK_W-1:0] peer_rank;
		logic [DATA_W-1:0] elem_count;
		logic [DATA_W-1:0] displacement;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_dst;
		logic take_src;
		logic take_dst;
		logic mul;
		logic init;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic div_done;
		logic last_peer;
	} dp_stat_t;

	function automatic logic [GRP_W-1:0] sat_grp(input logic [GRP_W-1:0] v);
		return (v > GRP_W'(MAX_RANKS)) ? GRP_W'(MAX_RANKS) : v;
	endfunction

endpackage

### sv/block_redistribution_counts.sv
// Top level of the block redistribution counter.
// A request word is taken when start is high and busy is low. The total is
// split into contiguous blocks over each group; one shared bit-serial divider
// runs two 32-step divisions (source group, then target group, or source group
// again when cmd is set), each ending with its done handshake; the multiply and
// init setup states follow, then one result word per peer rank comes out on
// consecutive cycles, each on result for a single cycle with strobe high, the
// final one with last set. The last word appears in the first cycle with busy
// low. A request with an empty source group, or an empty target group when cmd
// is clear, holds busy for one cycle and yields no words. The receiver cannot
// stall: every strobed word must be taken in the cycle it appears.
module block_redistribution_counts (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bdc_pkg::in_word_t   req,
	output logic                strobe,
	output bdc_pkg::out_word_t  result
);
	import bdc_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	bdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	bdc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule

### sv/bdc_div.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module bdc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bdc_pkg::DATA_W-1:0] dividend,
	input  logic [bdc_pkg::GRP_W-1:0]  divisor,
	output logic                       done,
	output logic [bdc_pkg::DATA_W-1:0] quotient,
	output logic [bdc_pkg::GRP_W-1:0]  remainder
);
	import bdc_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] dvd_q;
	logic [GRP_W-1:0]  rem_q;
	logic [GRP_W-1:0]  dsr_q;
	logic [GRP_W:0]    trial;
	logic [GRP_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DATA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], ge};
			rem_q <= ge ? diff[GRP_W-1:0] : trial[GRP_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("divider restarted while running");
`endif

endmodule

### sv/bdc_dp.sv
// Datapath: request registers, shared divider, block bounds and overlap counts.
module bdc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bdc_pkg::in_word_t   req,
	input  bdc_pkg::dp_cmd_t    ctl,
	output bdc_pkg::dp_stat_t   stat,
	output logic                strobe,
	output bdc_pkg::out_word_t  result
);
	import bdc_pkg::*;

	logic              cmd_q;
	logic [DATA_W-1:0] total_q;
	logic [RANK_W-1:0] me_q;
	logic [GRP_W-1:0]  src_n_q;
	logic [GRP_W-1:0]  dst_n_q;
	logic [DATA_W-1:0] stq_q;
	logic [GRP_W-1:0]  srm_q;
	logic [DATA_W-1:0] dtq_q;
	logic [GRP_W-1:0]  drm_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] mlo_q;
	logic [DATA_W-1:0] mhi_q;
	logic              empty_q;
	logic [DATA_W-1:0] olo_q;
	logic [DATA_W-1:0] ohi_q;
	logic [RANK_W-1:0] idx_q;
	logic [DATA_W-1:0] sum_q;
	logic              out_vld_q;
	out_word_t         out_q;

	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic [GRP_W-1:0]  div_rem;
	logic [GRP_W-1:0]  div_dsr;
	logic [GRP_W-1:0]  n_peers;
	logic              me_lt_rem;
	logic [GRP_W-1:0]  me_min;
	logic [DATA_W-1:0] mlo_d;
	logic [GRP_W-1:0]  idx_nxt;
	logic [DATA_W-1:0] lo;
	logic [DATA_W-1:0] hi;
	logic              ovl;
	logic [DATA_W-1:0] cnt;
	logic [DATA_W-1:0] disp;

	assign div_dsr = (ctl.div_dst && !cmd_q) ? dst_n_q : src_n_q;

	bdc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (total_q),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign n_peers   = cmd_q ? src_n_q : dst_n_q;
	assign me_lt_rem = {1'b0, me_q} < srm_q;
	assign me_min    = me_lt_rem ? {1'b0, me_q} : srm_q;
	assign mlo_d     = prod_q + DATA_W'(me_min);
	assign idx_nxt   = {1'b0, idx_q} + GRP_W'(1);

	assign lo   = (mlo_q > olo_q) ? mlo_q : olo_q;
	assign hi   = (mhi_q < ohi_q) ? mhi_q : ohi_q;
	assign ovl  = !empty_q && (hi > lo);
	assign cnt  = cmd_q ? (ohi_q - olo_q) : (ovl ? (hi - lo) : '0);
	assign disp = (cmd_q || ovl) ? sum_q : '0;

	assign stat.zero      = (src_n_q == '0) || (!cmd_q && (dst_n_q == '0));
	assign stat.div_done  = div_done;
	assign stat.last_peer = {1'b0, idx_q} == (n_peers - GRP_W'(1));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= req.cmd;
			total_q <= req.total_elements;
			me_q    <= req.my_rank;
			src_n_q <= sat_grp(req.source_ranks);
			dst_n_q <= sat_grp(req.dest_ranks);
		end
		if (ctl.take_src) begin
			stq_q <= div_quo;
			srm_q <= div_rem;
		end
		if (ctl.take_dst) begin
			dtq_q <= div_quo;
			drm_q <= div_rem;
		end
		if (ctl.mul) begin
			prod_q <= DATA_W'(stq_q * {{(DATA_W-RANK_W){1'b0}}, me_q});
		end
		if (ctl.init) begin
			mlo_q   <= mlo_d;
			mhi_q   <= mlo_d + stq_q + DATA_W'(me_lt_rem);
			empty_q <= {1'b0, me_q} >= src_n_q;
			olo_q   <= '0;
			ohi_q   <= dtq_q + DATA_W'(drm_q != '0);
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (ctl.emit) begin
			olo_q <= ohi_q;
			ohi_q <= ohi_q + dtq_q + DATA_W'(idx_nxt < drm_q);
			idx_q <= idx_q + RANK_W'(1);
			sum_q <= sum_q + cnt;
		end
		if (ctl.emit) begin
			out_q.peer_rank    <= idx_q;
			out_q.elem_count   <= cnt;
			out_q.displacement <= disp;
			out_q.last         <= stat.last_peer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= ctl.emit;
		end
	end

	assign strobe = out_vld_q;
	assign result = out_q;

`ifndef SYNTHESIS
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> ({1'b0, idx_q} < n_peers))
		else $error("result emitted past the last peer");
	a_emit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !stat.zero)
		else $error("result emitted for an empty group");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.last) |=> !out_vld_q)
		else $error("result word follows the last one");
`endif

endmodule

### sv/bdc_ctrl.sv
// Controller state machine sequencing divisions, setup and result emission.
module bdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bdc_pkg::dp_stat_t stat,
	output bdc_pkg::dp_cmd_t  ctl
);
	import bdc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_DSRC = 3'd2;
	localparam logic [2:0] S_DDST = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_INIT = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.zero) begin
					state_d = S_IDLE;
				end else begin
					ctl.div_start = 1'b1;
					state_d       = S_DSRC;
				end
			end
			S_DSRC: begin
				if (stat.div_done) begin
					ctl.take_src  = 1'b1;
					ctl.div_start = 1'b1;
					ctl.div_dst   = 1'b1;
					state_d       = S_DDST;
				end
			end
			S_DDST: begin
				if (stat.div_done) begin
					ctl.take_dst = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_INIT;
			end
			S_INIT: begin
				ctl.init = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				ctl.emit = 1'b1;
				if (stat.last_peer) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule
